// File: design/lmts_pkg.sv
package lmts_pkg;

    // field widths
    localparam int unsigned SEL_W  = 2;
    localparam int unsigned HZ_W   = 10;
    localparam int unsigned MS_W   = 11;
    localparam int unsigned NOTE_W = 6;
    localparam int unsigned CMP_W  = 8;

    // defaults for the top level parameters
    localparam int unsigned CLOCK_HZ_DEF = 16000000;
    localparam int unsigned PRESCALE_DEF = 256;
    localparam int unsigned GAP_MS_DEF   = 40;

    // the whole sequencer state is one ram entry
    localparam int unsigned STATE_DEPTH = 1;

    // request function codes
    localparam logic FUNC_TICK = 1'b0;
    localparam logic FUNC_LOOP = 1'b1;

    typedef enum logic [SEL_W-1:0] {
        MEL_MOVING   = 2'd0,
        MEL_DOOR     = 2'd1,
        MEL_OBSTACLE = 2'd2
    } melody_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_DIV,
        ST_DONE
    } seq_state_t;

    typedef struct packed {
        logic              looping;
        logic              gap_phase;
        logic [NOTE_W-1:0] note_position;
        logic [MS_W-1:0]   remaining_ms;
        logic              tone_on;
        logic [CMP_W-1:0]  tone_compare;
    } state_rec_t;

    localparam state_rec_t REC_RESET = '0;

    localparam logic [NOTE_W-1:0] MOVE_LEN    = 6'd18;
    localparam logic [NOTE_W-1:0] DOOR_LEN    = 6'd10;
    localparam logic [NOTE_W-1:0] OBST_LEN    = 6'd52;
    localparam logic [NOTE_W-1:0] MAX_MEL_LEN = OBST_LEN;

    localparam logic [HZ_W-1:0] MOVE_HZ [18] = '{
        10'd659, 10'd622, 10'd659, 10'd622, 10'd659, 10'd494, 10'd587, 10'd523, 10'd440,
        10'd220, 10'd262, 10'd330, 10'd440, 10'd494, 10'd165, 10'd208, 10'd247, 10'd330
    };
    localparam logic [MS_W-1:0] MOVE_MS [18] = '{
        11'd250, 11'd250, 11'd250, 11'd250, 11'd250, 11'd250, 11'd250, 11'd250, 11'd500,
        11'd250, 11'd250, 11'd250, 11'd500, 11'd500, 11'd250, 11'd250, 11'd250, 11'd500
    };

    localparam logic [HZ_W-1:0] DOOR_HZ [10] = '{
        10'd659, 10'd587, 10'd370, 10'd415, 10'd554,
        10'd494, 10'd294, 10'd330, 10'd494, 10'd440
    };
    localparam logic [MS_W-1:0] DOOR_MS [10] = '{
        11'd175, 11'd175, 11'd350, 11'd350, 11'd175,
        11'd175, 11'd350, 11'd350, 11'd175, 11'd725
    };

    localparam logic [HZ_W-1:0] OBST_HZ [52] = '{
        10'd740, 10'd740, 10'd659, 10'd440, 10'd494, 10'd587, 10'd494,
        10'd659, 10'd659, 10'd587, 10'd554, 10'd494, 10'd440, 10'd494, 10'd587, 10'd494,
        10'd587, 10'd659, 10'd554, 10'd494, 10'd440, 10'd440, 10'd440,
        10'd659, 10'd587, 10'd440, 10'd494, 10'd587, 10'd494,
        10'd740, 10'd740, 10'd659, 10'd440, 10'd494, 10'd587, 10'd494,
        10'd880, 10'd554, 10'd587, 10'd554, 10'd494, 10'd440, 10'd494, 10'd587, 10'd494,
        10'd587, 10'd659, 10'd554, 10'd494, 10'd440, 10'd440, 10'd440
    };
    localparam logic [MS_W-1:0] OBST_MS [52] = '{
        11'd395, 11'd395, 11'd789, 11'd132, 11'd132, 11'd132, 11'd132,
        11'd395, 11'd395, 11'd395, 11'd132, 11'd395, 11'd132, 11'd132, 11'd132, 11'd132,
        11'd526, 11'd263, 11'd395, 11'd132, 11'd263, 11'd263, 11'd263,
        11'd526, 11'd1053, 11'd132, 11'd132, 11'd132, 11'd132,
        11'd395, 11'd395, 11'd789, 11'd132, 11'd132, 11'd132, 11'd132,
        11'd526, 11'd263, 11'd395, 11'd132, 11'd263, 11'd132, 11'd132, 11'd132, 11'd132,
        11'd526, 11'd263, 11'd395, 11'd132, 11'd526, 11'd263, 11'd263
    };

    // the unused select code plays the moving melody
    function automatic melody_t mel_index(input logic [SEL_W-1:0] sel);
        melody_t m;
        unique case (sel)
            MEL_DOOR:     m = MEL_DOOR;
            MEL_OBSTACLE: m = MEL_OBSTACLE;
            default:      m = MEL_MOVING;
        endcase
        return m;
    endfunction

    function automatic logic [NOTE_W-1:0] mel_len(input melody_t m);
        logic [NOTE_W-1:0] len;
        unique case (m)
            MEL_DOOR:     len = DOOR_LEN;
            MEL_OBSTACLE: len = OBST_LEN;
            default:      len = MOVE_LEN;
        endcase
        return len;
    endfunction

    function automatic logic [HZ_W-1:0] mel_hz(input melody_t m, input logic [NOTE_W-1:0] pos);
        logic [HZ_W-1:0] hz;
        hz = '0;
        unique case (m)
            MEL_DOOR:     if (pos < DOOR_LEN) hz = DOOR_HZ[pos[3:0]];
            MEL_OBSTACLE: if (pos < OBST_LEN) hz = OBST_HZ[pos];
            default:      if (pos < MOVE_LEN) hz = MOVE_HZ[pos[4:0]];
        endcase
        return hz;
    endfunction

    function automatic logic [MS_W-1:0] mel_ms(input melody_t m, input logic [NOTE_W-1:0] pos);
        logic [MS_W-1:0] ms;
        ms = '0;
        unique case (m)
            MEL_DOOR:     if (pos < DOOR_LEN) ms = DOOR_MS[pos[3:0]];
            MEL_OBSTACLE: if (pos < OBST_LEN) ms = OBST_MS[pos];
            default:      if (pos < MOVE_LEN) ms = MOVE_MS[pos[4:0]];
        endcase
        return ms;
    endfunction

endpackage

// File: design/lmts_if.sv
interface lmts_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [lmts_pkg::SEL_W-1:0]  melody_select;

    modport source (output valid, output melody_select, input ready);
    modport sink   (input valid, input melody_select, output ready);
endinterface

interface lmts_req_if;
    logic valid;
    logic ready;
    logic func;
    logic loop_on;

    modport source (output valid, output func, output loop_on, input ready);
    modport sink   (input valid, input func, input loop_on, output ready);
endinterface

interface lmts_rsp_if;
    logic                        valid;
    logic                        ready;
    logic                        tone_on;
    logic [lmts_pkg::CMP_W-1:0]  tone_cmp;
    logic                        in_gap;
    logic [lmts_pkg::NOTE_W-1:0] current_note;
    logic [lmts_pkg::MS_W-1:0]   phase_left_ms;

    modport source (
        output valid, output tone_on, output tone_cmp, output in_gap,
        output current_note, output phase_left_ms, input ready
    );
    modport sink (
        input valid, input tone_on, input tone_cmp, input in_gap,
        input current_note, input phase_left_ms, output ready
    );
endinterface

// File: design/lmts_ram.sv
module lmts_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 1,
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: design/looping_melody_tone_sequencer.sv
// looping melody tone sequencer
//
// plays one of three fixed melodies in a loop, stepped by one millisecond
// ticks, and reports the tone timer setting after every request beat
// - cfg: melody_select write; accepted only while the block is idle, it picks
//   the melody and clears the sequencer state
// - req: func 0 is a 1 ms tick, func 1 turns the loop on or off from loop_on
// - rsp: one beat per request beat with tone_on, tone_cmp, in_gap,
//   current_note and phase_left_ms as they stand after the request
// sequence: an accepted request beat reads the ram, EXEC forms the new state
// and DONE loads the response into the output register once it is free; a
// request that starts a sounding note first runs the serial divider in DIV,
// one quotient bit per cycle; a request is taken only while idle, so one is
// in flight at a time, and the next request beat is taken as soon as the
// response is in the output register, even while rsp is stalled
// the state sits in a one-entry synchronous ram, read on acceptance and
// written back when the response is loaded
// reset: melody 0, loop off, tone off; the ram entry reads as cleared state
// a stalled rsp holds its beat, the next result waits and req stalls
module looping_melody_tone_sequencer #(
    parameter int unsigned CLOCK_HZ = lmts_pkg::CLOCK_HZ_DEF,
    parameter int unsigned PRESCALE = lmts_pkg::PRESCALE_DEF,
    parameter int unsigned GAP_MS   = lmts_pkg::GAP_MS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    lmts_cfg_if.sink           cfg,
    lmts_req_if.sink           req,
    lmts_rsp_if.source         rsp
);

    // divider sizing: dividend is the clock rate, divisor is 2*prescale*hz
    localparam int unsigned DVD_W = $clog2(CLOCK_HZ + 1);
    localparam int unsigned DSR_W = $clog2(2 * PRESCALE) + lmts_pkg::HZ_W;
    localparam int unsigned CNT_W = (DVD_W > 1) ? $clog2(DVD_W) : 1;
    localparam int unsigned AW    = (lmts_pkg::STATE_DEPTH > 1) ?
                                    $clog2(lmts_pkg::STATE_DEPTH) : 1;
    localparam int unsigned REC_W = $bits(lmts_pkg::state_rec_t);
    localparam int unsigned CMP_W = lmts_pkg::CMP_W;
    localparam int unsigned NOTE_W = lmts_pkg::NOTE_W;

    localparam logic [DVD_W-1:0] DIVIDEND     = DVD_W'(CLOCK_HZ);
    localparam logic [DSR_W-1:0] TWO_PRESCALE = DSR_W'(2 * PRESCALE);
    localparam logic [lmts_pkg::MS_W-1:0] GAP_LEN = lmts_pkg::MS_W'(GAP_MS);
    localparam logic [CNT_W-1:0] CNT_TOP      = CNT_W'(DVD_W - 1);

    lmts_pkg::seq_state_t state_reg, state_next;

    logic [lmts_pkg::SEL_W-1:0] melody_reg, melody_next;
    logic                       func_reg, func_next;
    logic                       en_reg, en_next;
    logic                       rec_valid_reg, rec_valid_next;

    lmts_pkg::state_rec_t work_reg, work_next;

    // serial divider, the partial remainder always stays below the divisor
    logic [DSR_W-1:0] dsr_reg, dsr_next;
    logic [DSR_W-1:0] rem_reg, rem_next;
    logic [CMP_W-1:0] quo_reg, quo_next;
    logic             sat_reg, sat_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    // output register
    logic                 rsp_valid_reg, rsp_valid_next;
    lmts_pkg::state_rec_t rsp_rec_reg, rsp_rec_next;

    // state ram
    logic             ram_we;
    logic             ram_re;
    logic [REC_W-1:0] ram_rdata;

    // exec stage terms
    lmts_pkg::state_rec_t   cur;
    lmts_pkg::state_rec_t   upd;
    lmts_pkg::melody_t      mel;
    logic [NOTE_W-1:0]      mel_length;
    logic [NOTE_W-1:0]      pos_pre;
    logic [NOTE_W:0]        pos_inc;
    logic [NOTE_W-1:0]      note_pos;
    logic [lmts_pkg::HZ_W-1:0] note_hz;
    logic                   start_note;
    logic                   need_div;
    logic [lmts_pkg::MS_W-1:0] rem_dec;

    // divider step terms
    logic [DSR_W:0]   shifted;
    logic             q_bit;
    logic [CMP_W-1:0] q_shift;
    logic             sat_step;
    logic [CMP_W-1:0] q_clamped;

    logic cfg_fire;
    logic req_fire;
    logic rsp_free;

    assign cfg.ready = (state_reg == lmts_pkg::ST_IDLE);
    // a config write wins over a request in the same cycle
    assign req.ready = (state_reg == lmts_pkg::ST_IDLE) && !cfg.valid;
    assign cfg_fire  = cfg.valid && cfg.ready;
    assign req_fire  = req.valid && req.ready;
    assign rsp_free  = !rsp_valid_reg || rsp.ready;

    lmts_ram #(
        .WIDTH (REC_W),
        .DEPTH (lmts_pkg::STATE_DEPTH)
    ) u_state_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (AW'(0)),
        .wdata (work_reg),
        .re    (ram_re),
        .raddr (AW'(0)),
        .rdata (ram_rdata)
    );

    // next state of the sequencer record for the accepted request
    always_comb
    begin
        cur        = rec_valid_reg ? lmts_pkg::state_rec_t'(ram_rdata) : lmts_pkg::REC_RESET;
        upd        = cur;
        mel        = lmts_pkg::mel_index(melody_reg);
        mel_length = lmts_pkg::mel_len(mel);
        pos_pre    = cur.note_position;
        pos_inc    = {1'b0, cur.note_position} + {{NOTE_W{1'b0}}, 1'b1};
        start_note = 1'b0;
        need_div   = 1'b0;
        rem_dec    = cur.remaining_ms - lmts_pkg::MS_W'(1);

        if (func_reg == lmts_pkg::FUNC_LOOP)
        begin
            if (en_reg != cur.looping)
            begin
                upd.looping = en_reg;
                if (!en_reg)
                begin
                    upd.gap_phase     = 1'b0;
                    upd.note_position = '0;
                    upd.remaining_ms  = '0;
                    upd.tone_on       = 1'b0;
                    upd.tone_compare  = '0;
                end
                else
                begin
                    pos_pre    = '0;
                    start_note = 1'b1;
                end
            end
        end
        else if (cur.looping && (cur.remaining_ms != '0))
        begin
            upd.remaining_ms = rem_dec;
            if (rem_dec == '0)
            begin
                if (cur.gap_phase)
                begin
                    // advance with wrap at the melody length
                    pos_pre    = (pos_inc >= {1'b0, mel_length}) ?
                                 '0 : pos_inc[NOTE_W-1:0];
                    start_note = 1'b1;
                end
                else
                begin
                    upd.tone_on      = 1'b0;
                    upd.tone_compare = '0;
                    upd.gap_phase    = 1'b1;
                    upd.remaining_ms = GAP_LEN;
                end
            end
        end

        // an index past the melody end plays note 0
        note_pos = (pos_pre >= mel_length) ? '0 : pos_pre;
        note_hz  = lmts_pkg::mel_hz(mel, note_pos);

        if (start_note)
        begin
            upd.note_position = note_pos;
            upd.gap_phase     = 1'b0;
            upd.remaining_ms  = lmts_pkg::mel_ms(mel, note_pos);
            upd.tone_compare  = '0;
            if (note_hz == '0)
            begin
                // rest note, tone stays off for its duration
                upd.tone_on = 1'b0;
            end
            else
            begin
                upd.tone_on = 1'b1;
                need_div    = 1'b1;
            end
        end
    end

    // one restoring division step per cycle, quotient saturates at 8 bits
    always_comb
    begin
        shifted   = {rem_reg, DIVIDEND[cnt_reg]};
        q_bit     = (shifted >= {1'b0, dsr_reg});
        q_shift   = {quo_reg[CMP_W-2:0], q_bit};
        sat_step  = sat_reg || quo_reg[CMP_W-1];
        // clamp to 1..255, then minus one
        q_clamped = sat_step ? {CMP_W{1'b1}} :
                    ((q_shift == '0) ? CMP_W'(1) : q_shift);
    end

    always_comb
    begin
        state_next     = state_reg;
        melody_next    = melody_reg;
        func_next      = func_reg;
        en_next        = en_reg;
        rec_valid_next = rec_valid_reg;
        work_next      = work_reg;
        dsr_next       = dsr_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        sat_next       = sat_reg;
        cnt_next       = cnt_reg;
        rsp_valid_next = rsp_valid_reg && !rsp.ready;
        rsp_rec_next   = rsp_rec_reg;
        ram_we         = 1'b0;
        ram_re         = 1'b0;

        unique case (state_reg)
            lmts_pkg::ST_IDLE:
            begin
                if (cfg_fire)
                begin
                    // new melody, the stored state reads as cleared again
                    melody_next    = cfg.melody_select;
                    rec_valid_next = 1'b0;
                end
                else if (req_fire)
                begin
                    func_next  = req.func;
                    en_next    = req.loop_on;
                    ram_re     = 1'b1;
                    state_next = lmts_pkg::ST_EXEC;
                end
            end
            lmts_pkg::ST_EXEC:
            begin
                work_next = upd;
                dsr_next  = DSR_W'(note_hz) * TWO_PRESCALE;
                rem_next  = '0;
                quo_next  = '0;
                sat_next  = 1'b0;
                cnt_next  = CNT_TOP;
                state_next = need_div ? lmts_pkg::ST_DIV : lmts_pkg::ST_DONE;
            end
            lmts_pkg::ST_DIV:
            begin
                rem_next = q_bit ? DSR_W'(shifted - {1'b0, dsr_reg}) : shifted[DSR_W-1:0];
                quo_next = q_shift;
                sat_next = sat_step;
                if (cnt_reg == '0)
                begin
                    work_next.tone_compare = q_clamped - CMP_W'(1);
                    state_next             = lmts_pkg::ST_DONE;
                end
                else
                begin
                    cnt_next = cnt_reg - CNT_W'(1);
                end
            end
            lmts_pkg::ST_DONE:
            begin
                if (rsp_free)
                begin
                    ram_we         = 1'b1;
                    rec_valid_next = 1'b1;
                    rsp_valid_next = 1'b1;
                    rsp_rec_next   = work_reg;
                    state_next     = lmts_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lmts_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lmts_pkg::ST_IDLE;
            melody_reg    <= lmts_pkg::MEL_MOVING;
            rec_valid_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            melody_reg    <= melody_next;
            rec_valid_reg <= rec_valid_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // payload and datapath registers
    always_ff @(posedge clk)
    begin
        func_reg    <= func_next;
        en_reg      <= en_next;
        work_reg    <= work_next;
        dsr_reg     <= dsr_next;
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
        sat_reg     <= sat_next;
        cnt_reg     <= cnt_next;
        rsp_rec_reg <= rsp_rec_next;
    end

    assign rsp.valid         = rsp_valid_reg;
    assign rsp.tone_on       = rsp_rec_reg.tone_on;
    assign rsp.tone_cmp      = rsp_rec_reg.tone_on ? rsp_rec_reg.tone_compare : '0;
    assign rsp.in_gap        = rsp_rec_reg.gap_phase;
    assign rsp.current_note  = rsp_rec_reg.note_position;
    assign rsp.phase_left_ms = rsp_rec_reg.remaining_ms;

endmodule

// File: design/lmts_checker.sv
module lmts_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        req_valid,
    input logic                        req_ready,
    input logic                        rsp_valid,
    input logic                        rsp_ready,
    input logic                        rsp_tone_on,
    input logic [lmts_pkg::CMP_W-1:0]  rsp_tone_cmp,
    input logic                        rsp_in_gap,
    input logic [lmts_pkg::NOTE_W-1:0] rsp_current_note,
    input logic [lmts_pkg::MS_W-1:0]   rsp_phase_left_ms
);

    // stalled beat holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable({rsp_tone_on, rsp_tone_cmp,
            rsp_in_gap, rsp_current_note, rsp_phase_left_ms}))
        else $error("rsp beat changed while stalled");

    // one request in flight at a time
    a_req_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while busy");

    a_tone_gap: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_in_gap |-> !rsp_tone_on && (rsp_tone_cmp == '0))
        else $error("tone running during gap");

    a_note_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp_current_note < lmts_pkg::MAX_MEL_LEN))
        else $error("note index past melody end");

endmodule

bind looping_melody_tone_sequencer lmts_checker u_lmts_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .req_valid         (req.valid),
    .req_ready         (req.ready),
    .rsp_valid         (rsp.valid),
    .rsp_ready         (rsp.ready),
    .rsp_tone_on       (rsp.tone_on),
    .rsp_tone_cmp      (rsp.tone_cmp),
    .rsp_in_gap        (rsp.in_gap),
    .rsp_current_note  (rsp.current_note),
    .rsp_phase_left_ms (rsp.phase_left_ms)
);
